// File: design/tsa_pkg.sv
// ----------------------------------------------------------------------------
// tsa_pkg
// shared widths, command and status types for the turnaround stats block
// ----------------------------------------------------------------------------
package tsa_pkg;

  localparam int FIELD_W     = 16;
  localparam int WTA_W       = 32;
  localparam int PCT_W       = 7;
  localparam int ACC_MAX_W   = 64;
  localparam int PERCENT_SCALE = 100;
  localparam int IN_DATA_W   = 64;
  localparam int OUT_DATA_W  = 136;
  localparam int OUT_USER_W  = 2;
  localparam int STEP_W      = 7;

  localparam int DEF_TIME_BITS = 16;
  localparam int DEF_MAX_JOBS  = 1024;
  localparam int DEF_FRAC_BITS = 16;

  typedef enum logic [2:0] {
    DIV_WTA,
    DIV_CPU,
    DIV_MT,
    DIV_MW,
    DIV_MSQ
  } div_sel_t;

  typedef enum logic {
    MUL_WTA,
    MUL_MT
  } mul_sel_t;

  typedef struct packed {
    logic     capture;
    logic     div_start;
    div_sel_t div_sel;
    logic     mul_go;
    mul_sel_t mul_sel;
    logic     accumulate;
    logic     sqrt_start;
    logic     out_load;
    logic     clear;
  } tsa_cmd_t;

  typedef struct packed {
    logic div_done;
    logic sqrt_done;
    logic run_zero;
    logic end_zero;
    logic last;
    logic out_free;
  } tsa_status_t;

  function automatic logic [WTA_W-1:0] sat32(input logic [ACC_MAX_W-1:0] v);
    logic [WTA_W-1:0] r;
    if (|v[ACC_MAX_W-1:WTA_W]) r = '1;
    else r = v[WTA_W-1:0];
    return r;
  endfunction

endpackage

// File: design/tsa_div.sv
// ----------------------------------------------------------------------------
// tsa_div
// restoring divider, one quotient bit per cycle, numerator left aligned
// ----------------------------------------------------------------------------
module tsa_div #(
  parameter int DEN_W = 16
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [tsa_pkg::ACC_MAX_W-1:0] num,
  input  logic [DEN_W-1:0]           den,
  input  logic [tsa_pkg::STEP_W-1:0] steps,
  output logic                       done,
  output logic [tsa_pkg::ACC_MAX_W-1:0] quot
);
  import tsa_pkg::*;

  logic [ACC_MAX_W-1:0] nreg;
  logic [DEN_W-1:0]     rem;
  logic [DEN_W-1:0]     dreg;
  logic [STEP_W-1:0]    cnt;
  logic                 busy;
  logic [DEN_W:0]       rem_sh;
  logic [DEN_W:0]       rem_sub;
  logic                 ge;

  assign rem_sh  = {rem, nreg[ACC_MAX_W-1]};
  assign ge      = rem_sh >= {1'b0, dreg};
  assign rem_sub = rem_sh - {1'b0, dreg};
  assign quot    = nreg;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= steps;
        nreg <= num;
        dreg <= den;
        rem  <= '0;
      end else if (busy) begin
        nreg <= {nreg[ACC_MAX_W-2:0], ge};
        rem  <= ge ? rem_sub[DEN_W-1:0] : rem_sh[DEN_W-1:0];
        cnt  <= cnt - 1'b1;
        if (cnt == STEP_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

// File: design/tsa_sqrt.sv
// ----------------------------------------------------------------------------
// tsa_sqrt
// integer square root of a 64-bit value, one result bit per cycle
// ----------------------------------------------------------------------------
module tsa_sqrt (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [tsa_pkg::ACC_MAX_W-1:0] x_in,
  output logic                          done,
  output logic [tsa_pkg::WTA_W-1:0]     root
);
  import tsa_pkg::*;

  localparam int CNT_W = $clog2(ACC_MAX_W / 2 + 1);

  logic [ACC_MAX_W-1:0] x;
  logic [ACC_MAX_W-1:0] res;
  logic [ACC_MAX_W-1:0] bitv;
  logic [CNT_W-1:0]     cnt;
  logic                 busy;
  logic [ACC_MAX_W-1:0] trial;

  assign trial = res + bitv;
  assign root  = res[WTA_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(ACC_MAX_W / 2);
        x    <= x_in;
        res  <= '0;
        bitv <= {2'b01, {(ACC_MAX_W-2){1'b0}}};
      end else if (busy) begin
        if (x >= trial) begin
          x   <= x - trial;
          res <= (res >> 1) + bitv;
        end else begin
          res <= res >> 1;
        end
        bitv <= bitv >> 2;
        cnt  <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

// File: design/tsa_datapath.sv
// ----------------------------------------------------------------------------
// tsa_datapath
// input capture, accumulators, shared divider, multiplier, root and output
// ----------------------------------------------------------------------------
module tsa_datapath #(
  parameter int TIME_BITS = tsa_pkg::DEF_TIME_BITS,
  parameter int MAX_JOBS  = tsa_pkg::DEF_MAX_JOBS,
  parameter int FRAC_BITS = tsa_pkg::DEF_FRAC_BITS
) (
  input  logic                           clk,
  input  logic                           rst,
  input  tsa_pkg::tsa_cmd_t              cmd,
  output tsa_pkg::tsa_status_t           status,
  input  logic [tsa_pkg::IN_DATA_W-1:0]  s_tdata,
  input  logic                           s_tlast,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [tsa_pkg::OUT_DATA_W-1:0] m_tdata,
  output logic [tsa_pkg::OUT_USER_W-1:0] m_tuser
);
  import tsa_pkg::*;

  localparam int TW     = TIME_BITS < FIELD_W ? TIME_BITS : FIELD_W;
  localparam int CW     = $clog2(MAX_JOBS + 1);
  localparam int DW     = TW > CW ? TW : CW;
  localparam int RT_W   = TW + CW;
  localparam int TT_W   = WTA_W + CW;
  localparam int SQ_RAW = ACC_MAX_W - FRAC_BITS + CW;
  localparam int SQ_W   = SQ_RAW < ACC_MAX_W ? SQ_RAW : ACC_MAX_W;
  localparam int WSTEPS = TW + FRAC_BITS;
  localparam int CPU_W  = RT_W + 7;

  logic [TW-1:0]        arr, endt, run, wait_t;
  logic                 last;
  logic [WTA_W-1:0]     wta;
  logic                 zero_err;
  logic [2*WTA_W-1:0]   prod;
  logic [TW-1:0]        latest_end;
  logic [RT_W-1:0]      run_total, wait_total;
  logic [TT_W-1:0]      tt_total;
  logic [SQ_W-1:0]      sq_total;
  logic [CW-1:0]        job_count;
  logic [PCT_W-1:0]     cpu;
  logic [WTA_W-1:0]     mean_t, mean_w, dev;
  logic [SQ_W-1:0]      mean_sq;
  div_sel_t             cur_sel;
  logic                 out_valid;
  logic                 dev_ready;

  logic [TW-1:0]        diff;
  logic [ACC_MAX_W-1:0] div_num;
  logic [DW-1:0]        div_den;
  logic [STEP_W-1:0]    div_steps;
  logic                 div_done;
  logic [ACC_MAX_W-1:0] quot;
  logic [CPU_W-1:0]     cpu_num;
  logic [WTA_W-1:0]     mul_a;
  logic [ACC_MAX_W-1:0] m_sq, var_v, sqrt_x;
  logic                 sqrt_done;
  logic [WTA_W-1:0]     root;
  logic                 out_free;

  assign diff    = endt >= arr ? endt - arr : '0;
  assign cpu_num = (CPU_W'(run_total) << 6) + (CPU_W'(run_total) << 5)
                 + (CPU_W'(run_total) << 2);

  always_comb begin
    div_num   = '0;
    div_den   = DW'(job_count);
    div_steps = STEP_W'(ACC_MAX_W);
    unique case (cmd.div_sel)
      DIV_WTA: begin
        div_num   = {diff, {FRAC_BITS{1'b0}}, {(ACC_MAX_W-WSTEPS){1'b0}}};
        div_den   = DW'(run);
        div_steps = STEP_W'(WSTEPS);
      end
      DIV_CPU: begin
        div_num = ACC_MAX_W'(cpu_num);
        div_den = DW'(latest_end);
      end
      DIV_MT:  div_num = ACC_MAX_W'(tt_total);
      DIV_MW:  div_num = ACC_MAX_W'({wait_total, {FRAC_BITS{1'b0}}});
      DIV_MSQ: div_num = ACC_MAX_W'(sq_total);
      default: div_num = '0;
    endcase
  end

  tsa_div #(.DEN_W(DW)) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.div_start),
    .num   (div_num),
    .den   (div_den),
    .steps (div_steps),
    .done  (div_done),
    .quot  (quot)
  );

  // variance from the mean square and the squared mean
  assign m_sq   = prod >> FRAC_BITS;
  assign var_v  = ACC_MAX_W'(mean_sq) > m_sq ? ACC_MAX_W'(mean_sq) - m_sq : '0;
  assign sqrt_x = var_v << FRAC_BITS;

  tsa_sqrt u_sqrt (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.sqrt_start),
    .x_in  (sqrt_x),
    .done  (sqrt_done),
    .root  (root)
  );

  assign mul_a    = cmd.mul_sel == MUL_WTA ? wta : mean_t;
  assign out_free = !out_valid || m_tready;

  always_comb begin
    status.div_done  = div_done;
    status.sqrt_done = dev_ready;
    status.run_zero  = run == '0;
    status.end_zero  = latest_end == '0;
    status.last      = last;
    status.out_free  = out_free;
  end

  // deviation ready flag marks a fresh root until the next root starts
  always_ff @(posedge clk) begin
    if (rst) begin
      dev_ready <= 1'b0;
    end else if (cmd.sqrt_start) begin
      dev_ready <= 1'b0;
    end else if (sqrt_done) begin
      dev_ready <= 1'b1;
    end
  end

  // job record and summary registers
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      arr    <= s_tdata[0 +: TW];
      endt   <= s_tdata[FIELD_W +: TW];
      run    <= s_tdata[2*FIELD_W +: TW];
      wait_t <= s_tdata[3*FIELD_W +: TW];
      last   <= s_tlast;
      cpu    <= '0;
      wta    <= '1;
      zero_err <= s_tdata[2*FIELD_W +: TW] == '0;
    end
    if (cmd.div_start) cur_sel <= cmd.div_sel;
    if (div_done) begin
      unique case (cur_sel)
        DIV_WTA: wta <= sat32(quot);
        DIV_CPU: cpu <= quot > ACC_MAX_W'(PERCENT_SCALE) ? PCT_W'(PERCENT_SCALE)
                                                         : quot[PCT_W-1:0];
        DIV_MT:  mean_t <= sat32(quot);
        DIV_MW:  mean_w <= sat32(quot);
        DIV_MSQ: mean_sq <= quot[SQ_W-1:0];
        default: mean_sq <= mean_sq;
      endcase
    end
    if (cmd.mul_go) prod <= mul_a * mul_a;
    if (sqrt_done) dev <= root;
  end

  // accumulators
  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      latest_end <= '0;
      run_total  <= '0;
      wait_total <= '0;
      tt_total   <= '0;
      sq_total   <= '0;
      job_count  <= '0;
    end else if (cmd.accumulate && job_count < CW'(MAX_JOBS)) begin
      if (endt > latest_end) latest_end <= endt;
      run_total  <= run_total + RT_W'(run);
      wait_total <= wait_total + RT_W'(wait_t);
      tt_total   <= tt_total + TT_W'(wta);
      sq_total   <= sq_total + SQ_W'(prod >> FRAC_BITS);
      job_count  <= job_count + 1'b1;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
    if (cmd.out_load) begin
      m_tdata <= {1'b0,
                  last ? dev : '0,
                  last ? mean_w : '0,
                  last ? mean_t : '0,
                  last ? cpu : '0,
                  wta};
      m_tuser <= {last, zero_err};
    end
  end

  assign m_tvalid = out_valid;

endmodule

// File: design/tsa_ctrl.sv
// ----------------------------------------------------------------------------
// tsa_ctrl
// sequencer for one job record and the closing summary
// ----------------------------------------------------------------------------
module tsa_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  tsa_pkg::tsa_status_t status,
  output tsa_pkg::tsa_cmd_t    cmd
);
  import tsa_pkg::*;

  typedef enum logic [3:0] {
    IDLE, WTA_START, WTA_DIV, SQ_MUL, ACC,
    CPU_START, CPU_DIV, MT_START, MT_DIV, MW_START, MW_DIV,
    MSQ_START, MSQ_DIV, MT_MUL, SQRT_RUN, OUT
  } state_t;

  state_t state, state_next;

  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd.div_sel = DIV_WTA;
    cmd.mul_sel = MUL_WTA;
    s_tready   = state == IDLE;
    unique case (state)
      IDLE: if (s_tvalid) begin
        cmd.capture = 1'b1;
        state_next  = WTA_START;
      end
      WTA_START: begin
        if (status.run_zero) begin
          state_next = SQ_MUL;
        end else begin
          cmd.div_start = 1'b1;
          state_next    = WTA_DIV;
        end
      end
      WTA_DIV: if (status.div_done) state_next = SQ_MUL;
      SQ_MUL: begin
        cmd.mul_go = 1'b1;
        state_next = ACC;
      end
      ACC: begin
        cmd.accumulate = 1'b1;
        state_next = status.last ? CPU_START : OUT;
      end
      CPU_START: begin
        if (status.end_zero) begin
          state_next = MT_START;
        end else begin
          cmd.div_start = 1'b1;
          cmd.div_sel   = DIV_CPU;
          state_next    = CPU_DIV;
        end
      end
      CPU_DIV: if (status.div_done) state_next = MT_START;
      MT_START: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = DIV_MT;
        state_next    = MT_DIV;
      end
      MT_DIV: if (status.div_done) state_next = MW_START;
      MW_START: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = DIV_MW;
        state_next    = MW_DIV;
      end
      MW_DIV: if (status.div_done) state_next = MSQ_START;
      MSQ_START: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = DIV_MSQ;
        state_next    = MSQ_DIV;
      end
      MSQ_DIV: if (status.div_done) state_next = MT_MUL;
      MT_MUL: begin
        cmd.mul_go  = 1'b1;
        cmd.mul_sel = MUL_MT;
        state_next  = SQRT_RUN;
      end
      SQRT_RUN: begin
        // root starts with the squared mean now in the product register
        cmd.sqrt_start = 1'b1;
        state_next     = OUT;
      end
      // summary waits for the root to finish before loading the output
      OUT: if (status.out_free && (!status.last || status.sqrt_done)) begin
        cmd.out_load = 1'b1;
        cmd.clear    = status.last;
        state_next   = IDLE;
      end
      default: state_next = IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= IDLE;
    else state <= state_next;
  end

endmodule

// File: design/turnaround_stats_accumulator.sv
// ----------------------------------------------------------------------------
// turnaround_stats_accumulator
// per-job weighted turnaround with running statistics and a closing summary
// ----------------------------------------------------------------------------
// a job is paced by the shared bit-serial divider; a zero run time skips the divide
// a last job adds four 64-step divides (the CPU divide skipped at a zero latest end)
//   and a 32-step square root
// throughput: one transaction in flight; next input taken once a result is queued
// reset: synchronous, clears the sequencer, accumulators and output valid
// ----------------------------------------------------------------------------
module turnaround_stats_accumulator #(
  parameter int TIME_BITS = tsa_pkg::DEF_TIME_BITS,
  parameter int MAX_JOBS  = tsa_pkg::DEF_MAX_JOBS,
  parameter int FRAC_BITS = tsa_pkg::DEF_FRAC_BITS
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  // arrival_time, end_time, run_time, waiting_time
  input  logic [tsa_pkg::IN_DATA_W-1:0]  s_tdata,
  input  logic                           s_tlast,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  // weighted_turnaround, cpu_percent, mean_turnaround, mean_waiting,
  // turnaround_deviation, zero pad
  output logic [tsa_pkg::OUT_DATA_W-1:0] m_tdata,
  // zero_run_error, summary_valid
  output logic [tsa_pkg::OUT_USER_W-1:0] m_tuser
);
  import tsa_pkg::*;

  tsa_cmd_t    cmd;
  tsa_status_t status;

  tsa_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  tsa_datapath #(
    .TIME_BITS (TIME_BITS),
    .MAX_JOBS  (MAX_JOBS),
    .FRAC_BITS (FRAC_BITS)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .status   (status),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

endmodule
